FILE: hdl/cah_pkg.sv
// Shared types, constants and the bucket hash for the chained address hash table.
// No dependencies; every other file imports this package.
`default_nettype none
package cah_pkg;

	localparam int unsigned BUCKETS_DEF = 1024;
	localparam int unsigned ENTRIES_DEF = 1024;
	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned REQ_W       = 2;
	localparam int unsigned SLOT_W      = 10;
	localparam int unsigned SLOT_BYTES_W = 16;

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_FOUND    = 2'd0,
		ST_INSERTED = 2'd1,
		ST_MISS     = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
	} result_t;

	// free list commands and availability
	typedef struct packed {
		logic alloc;
		logic recycle;
	} fl_cmd_t;

	typedef struct packed {
		logic recycled;
		logic fresh;
	} fl_stat_t;

	function automatic logic [ADDR_W-1:0] bucket_hash(input logic [ADDR_W-1:0] addr);
		return (addr >> 14) ^ ((addr >> 2) & 32'h0000_ffff);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/chained_address_hash_table.sv
// Top level of the chained address hash table: chain walker, free list and output register.
// Depends on cah_pkg, cah_free_list and cah_table.
`default_nettype none
// Keeps a set of 32-bit addresses in ENTRIES slots chained from BUCKETS bucket heads
// (power of two). After reset the block clears its bucket head memory and takes no
// transaction until then. A request reads its bucket head, walks the chain until the hit
// or the end of the chain, then acts on the result; an insert that takes a new slot writes
// it in one further step. Each chain entry costs one read of the key and link memories.
// One request is worked on at a time; a finished result waits in the output register
// while the next request is taken.
module chained_address_hash_table #(
	parameter int unsigned BUCKETS = cah_pkg::BUCKETS_DEF,
	parameter int unsigned ENTRIES = cah_pkg::ENTRIES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // addr[31:0]
	input  wire  [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // slot[9:0], zeros[15:10]
	output logic [1:0]  m_tuser    // status[1:0]
);
	import cah_pkg::*;

	localparam int unsigned EW = $clog2(ENTRIES);

	fl_cmd_t       fl_cmd;
	fl_stat_t      fl_stat;
	logic [EW-1:0] release_slot;
	logic [EW-1:0] alloc_slot;
	logic          res_valid;
	logic          res_ready;
	result_t       res;
	result_t       out_q;
	logic          out_valid_q;

	cah_free_list #(.ENTRIES(ENTRIES)) u_free_list (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (fl_cmd),
		.release_slot (release_slot),
		.stat         (fl_stat),
		.alloc_slot   (alloc_slot)
	);

	cah_table #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_req       (s_tuser),
		.in_addr      (s_tdata),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.fl_cmd       (fl_cmd),
		.fl_stat      (fl_stat),
		.release_slot (release_slot),
		.alloc_slot   (alloc_slot)
	);

	assign res_ready = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tuser   = out_q.status;
	assign m_tdata   = SLOT_BYTES_W'(out_q.slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) out_q <= res;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/cah_free_list.sv
// Free slot allocator: recycled-slot stack in a synchronous memory plus a fresh counter.
// Depends on cah_pkg.
`default_nettype none
module cah_free_list #(
	parameter int unsigned ENTRIES = cah_pkg::ENTRIES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  cah_pkg::fl_cmd_t             cmd,
	input  wire [$clog2(ENTRIES)-1:0]    release_slot,
	output cah_pkg::fl_stat_t            stat,
	output logic [$clog2(ENTRIES)-1:0]   alloc_slot
);
	import cah_pkg::*;

	localparam int unsigned EW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	logic [EW-1:0] stack_mem [ENTRIES];
	logic [CW-1:0] rcount_q;
	logic [CW-1:0] fresh_q;
	logic [CW-1:0] top_idx;
	logic [EW-1:0] pop_data_q;
	logic [EW-1:0] fresh_slot_q;
	logic          from_stack_q;

	assign top_idx       = rcount_q - CW'(1);
	assign stat.recycled = (rcount_q != '0);
	assign stat.fresh    = (fresh_q != CW'(ENTRIES));
	assign alloc_slot    = from_stack_q ? pop_data_q : fresh_slot_q;

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			pop_data_q <= stack_mem[top_idx[EW-1:0]];
		end
		if (cmd.recycle && rcount_q != CW'(ENTRIES)) begin
			stack_mem[rcount_q[EW-1:0]] <= release_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			from_stack_q <= stat.recycled;
			fresh_slot_q <= fresh_q[EW-1:0];
		end
	end

	// recycled slots go first, last in first out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcount_q <= '0;
			fresh_q  <= '0;
		end else if (cmd.alloc) begin
			if (stat.recycled) begin
				rcount_q <= top_idx;
			end else if (stat.fresh) begin
				fresh_q <= fresh_q + CW'(1);
			end
		end else if (cmd.recycle && rcount_q != CW'(ENTRIES)) begin
			rcount_q <= rcount_q + CW'(1);
		end
	end

endmodule
`default_nettype wire

FILE: hdl/cah_table.sv
// Chain walker: bucket head, key and link memories and the request sequencer.
// Depends on cah_pkg; drives cah_free_list through a command struct.
`default_nettype none
module cah_table #(
	parameter int unsigned BUCKETS = cah_pkg::BUCKETS_DEF,
	parameter int unsigned ENTRIES = cah_pkg::ENTRIES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [cah_pkg::REQ_W-1:0]     in_req,
	input  wire [cah_pkg::ADDR_W-1:0]    in_addr,
	output logic                         res_valid,
	input  wire                          res_ready,
	output cah_pkg::result_t             res,
	output cah_pkg::fl_cmd_t             fl_cmd,
	input  cah_pkg::fl_stat_t            fl_stat,
	output logic [$clog2(ENTRIES)-1:0]   release_slot,
	input  wire [$clog2(ENTRIES)-1:0]    alloc_slot
);
	import cah_pkg::*;

	localparam int unsigned BW = $clog2(BUCKETS);
	localparam int unsigned EW = $clog2(ENTRIES);
	localparam int unsigned LW = $clog2(ENTRIES + 1);
	localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HEAD, S_WALK, S_ACT, S_ALLOC, S_DONE
	} state_t;

	logic [LW-1:0]     head_mem [BUCKETS];
	logic [ADDR_W-1:0] key_mem  [ENTRIES];
	logic [LW-1:0]     link_mem [ENTRIES];

	state_t            state_q;
	logic [BW-1:0]     clr_q;
	logic [REQ_W-1:0]  req_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BW-1:0]     bkt_q;
	logic [LW-1:0]     head_q;
	logic [LW-1:0]     cur_q;
	logic [LW-1:0]     prev_q;
	logic [LW-1:0]     steps_q;
	logic              hit_q;
	logic [LW-1:0]     hit_link_q;
	result_t           res_q;

	logic [LW-1:0]     head_rd;
	logic [ADDR_W-1:0] key_rd;
	logic [LW-1:0]     link_rd;

	logic              head_re, head_we;
	logic [BW-1:0]     head_ra, head_wa;
	logic [LW-1:0]     head_wd;
	logic              ent_re, key_we, link_we;
	logic [EW-1:0]     ent_ra, ent_wa;
	logic [LW-1:0]     link_wd;
	logic [ADDR_W-1:0] hash_in;
	logic              key_hit, walk_end;

	assign hash_in   = bucket_hash(in_addr);
	assign key_hit   = (key_rd == addr_q);
	assign walk_end  = (link_rd >= NULL_LINK) || (steps_q + LW'(1) == NULL_LINK);
	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;
	assign release_slot = cur_q[EW-1:0];

	always_comb begin
		head_re = 1'b0; head_we = 1'b0;
		head_ra = hash_in[BW-1:0]; head_wa = bkt_q; head_wd = NULL_LINK;
		ent_re = 1'b0; key_we = 1'b0; link_we = 1'b0;
		ent_ra = head_rd[EW-1:0]; ent_wa = alloc_slot; link_wd = head_q;
		fl_cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				head_we = 1'b1;
				head_wa = clr_q;
			end
			S_IDLE: head_re = in_valid;
			S_HEAD: ent_re = (head_rd < NULL_LINK);
			S_WALK: begin
				ent_re = !key_hit && !walk_end;
				ent_ra = link_rd[EW-1:0];
			end
			S_ACT: begin
				if (req_q == REQ_INSERT && !hit_q) begin
					fl_cmd.alloc = fl_stat.recycled || fl_stat.fresh;
				end else if (req_q == REQ_REMOVE && hit_q) begin
					// unlink from the head or from the predecessor
					fl_cmd.recycle = 1'b1;
					if (prev_q >= NULL_LINK) begin
						head_we = 1'b1;
						head_wd = hit_link_q;
					end else begin
						link_we = 1'b1;
						ent_wa  = prev_q[EW-1:0];
						link_wd = hit_link_q;
					end
				end
			end
			S_ALLOC: begin
				key_we  = 1'b1;
				link_we = 1'b1;
				head_we = 1'b1;
				head_wd = LW'(alloc_slot);
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_re) head_rd <= head_mem[head_ra];
		if (head_we) head_mem[head_wa] <= head_wd;
	end

	always_ff @(posedge clk) begin
		if (ent_re) begin
			key_rd  <= key_mem[ent_ra];
			link_rd <= link_mem[ent_ra];
		end
		if (key_we)  key_mem[ent_wa]  <= addr_q;
		if (link_we) link_mem[ent_wa] <= link_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			req_q      <= '0;
			addr_q     <= '0;
			bkt_q      <= '0;
			head_q     <= '0;
			cur_q      <= '0;
			prev_q     <= '0;
			steps_q    <= '0;
			hit_q      <= 1'b0;
			hit_link_q <= '0;
			res_q      <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_q == BW'(BUCKETS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= in_req;
						addr_q  <= in_addr;
						bkt_q   <= hash_in[BW-1:0];
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					head_q  <= head_rd;
					cur_q   <= head_rd;
					prev_q  <= NULL_LINK;
					steps_q <= '0;
					hit_q   <= 1'b0;
					state_q <= (head_rd < NULL_LINK) ? S_WALK : S_ACT;
				end
				S_WALK: begin
					if (key_hit) begin
						hit_q      <= 1'b1;
						hit_link_q <= link_rd;
						state_q    <= S_ACT;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= link_rd;
						steps_q <= steps_q + LW'(1);
						if (walk_end) state_q <= S_ACT;
					end
				end
				S_ACT: begin
					if (req_q == REQ_INSERT && !hit_q) begin
						if (fl_stat.recycled || fl_stat.fresh) begin
							state_q <= S_ALLOC;
						end else begin
							res_q   <= '{status: ST_FULL, slot: '0};
							state_q <= S_DONE;
						end
					end else begin
						if (hit_q) res_q <= '{status: ST_FOUND, slot: SLOT_W'(cur_q[EW-1:0])};
						else       res_q <= '{status: ST_MISS, slot: '0};
						state_q <= S_DONE;
					end
				end
				S_ALLOC: begin
					res_q   <= '{status: ST_INSERTED, slot: SLOT_W'(alloc_slot)};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: verif/chained_address_hash_table_tb.sv
// Testbench for chained_address_hash_table: drives lookup, insert and remove requests
// and checks each status and slot against a scoreboard that keeps its own chained table.
// Depends on cah_pkg and the block's RTL.
`default_nettype none
module chained_address_hash_table_tb;
	import cah_pkg::*;

	localparam int unsigned NBKT = 1024;
	localparam int unsigned NENT = 1024;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD = 300;

	// Shadow table: bucket heads, entry keys and links, free slot bookkeeping.
	class hash_table_scoreboard;
		int unsigned head[NBKT];
		logic [31:0] key[NENT];
		int unsigned link[NENT];
		int unsigned recycled[NENT];
		int unsigned recycled_cnt;
		int unsigned fresh_cnt;
		result_t expected_results[$];
		int errors;

		function new();
			foreach (head[i]) head[i] = NENT;
			recycled_cnt = 0;
			fresh_cnt = 0;
			errors = 0;
		endfunction

		function automatic int unsigned bucket_index(logic [31:0] a);
			return int'(a[23:14] ^ a[11:2]);
		endfunction

		// Note an accepted request: update the shadow table and queue its result.
		function void note_request(logic [1:0] req, logic [31:0] a);
			int unsigned b, cur, prv, hit, steps, s;
			result_t r;
			b = bucket_index(a);
			cur = head[b];
			prv = NENT;
			hit = NENT;
			steps = 0;
			while (cur < NENT && steps < NENT) begin
				if (key[cur] == a) begin
					hit = cur;
					break;
				end
				prv = cur;
				cur = link[cur];
				steps++;
			end
			if (hit == NENT) prv = NENT;
			r.status = ST_MISS;
			r.slot = '0;
			if (req == REQ_INSERT) begin
				if (hit < NENT) begin
					r.status = ST_FOUND;
					r.slot = hit[SLOT_W-1:0];
				end else begin
					s = NENT;
					if (recycled_cnt > 0) begin
						recycled_cnt--;
						s = recycled[recycled_cnt];
					end else if (fresh_cnt < NENT) begin
						s = fresh_cnt;
						fresh_cnt++;
					end
					if (s < NENT) begin
						key[s] = a;
						link[s] = head[b];
						head[b] = s;
						r.status = ST_INSERTED;
						r.slot = s[SLOT_W-1:0];
					end else begin
						r.status = ST_FULL;
					end
				end
			end else if (req == REQ_REMOVE) begin
				if (hit < NENT) begin
					if (prv < NENT) link[prv] = link[hit];
					else head[b] = link[hit];
					if (recycled_cnt < NENT) begin
						recycled[recycled_cnt] = hit;
						recycled_cnt++;
					end
					r.status = ST_FOUND;
					r.slot = hit[SLOT_W-1:0];
				end
			end else if (hit < NENT) begin
				r.status = ST_FOUND;
				r.slot = hit[SLOT_W-1:0];
			end
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [15:0] data);
			result_t e;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d slot %0d", st, data[9:0]);
				return;
			end
			e = expected_results.pop_front();
			if (st !== e.status || data[9:0] !== e.slot || data[15:10] !== 6'd0) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected status %0d slot %0d, got status %0d data %h",
						e.status, e.slot, st, data);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;
	logic [1:0] m_tuser;

	hash_table_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_req;
	int quiet_cycles;
	logic [31:0] addr_pool[48];

	chained_address_hash_table DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one request and hold it until the transaction completes.
	task automatic send_request(logic [1:0] req, logic [31:0] a);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= a;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(req, a);
		// idle each following cycle with the sender's idle chance
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_addr();
		if ($urandom_range(99) < 75) return addr_pool[$urandom_range(47)];
		return $urandom();
	endfunction

	function automatic logic [1:0] pick_req();
		int p;
		p = $urandom_range(99);
		if (p < 45) return REQ_INSERT;
		if (p < 70) return REQ_REMOVE;
		if (p < 95) return REQ_LOOKUP;
		return REQ_UNUSED;
	endfunction

	task automatic random_run(int count);
		repeat (count) send_request(pick_req(), pick_addr());
	endtask

	initial begin
		logic [31:0] base;
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= REQ_LOOKUP;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		// Pool in groups of eight: bits outside the hash differ, so each group shares a bucket.
		for (int g = 0; g < 6; g++) begin
			base = $urandom();
			for (int k = 0; k < 8; k++)
				addr_pool[g*8+k] = {base[31:24] ^ 8'($urandom()), base[23:14],
					2'($urandom()), base[11:2], 2'($urandom())};
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, duplicates, chains in one bucket, slot reuse, unused type.
		send_request(REQ_LOOKUP, 32'h0000_0000);
		send_request(REQ_REMOVE, 32'hffff_ffff);
		send_request(REQ_INSERT, 32'h0000_0000);
		send_request(REQ_INSERT, 32'hffff_ffff);
		send_request(REQ_INSERT, 32'h0000_0000);
		send_request(REQ_INSERT, 32'h0000_0001);
		send_request(REQ_INSERT, 32'hff00_3002);
		send_request(REQ_INSERT, 32'h8000_0003);
		send_request(REQ_LOOKUP, 32'h0000_0001);
		send_request(REQ_UNUSED, 32'hffff_ffff);
		send_request(REQ_UNUSED, 32'h1234_5678);
		send_request(REQ_REMOVE, 32'hff00_3002);
		send_request(REQ_LOOKUP, 32'h8000_0003);
		send_request(REQ_REMOVE, 32'h0000_0001);
		send_request(REQ_REMOVE, 32'h0000_0001);
		send_request(REQ_INSERT, 32'h4000_1000);
		send_request(REQ_INSERT, 32'h0000_3003);
		send_request(REQ_INSERT, 32'h5555_aaaa);
		send_request(REQ_REMOVE, 32'h0000_0000);
		send_request(REQ_LOOKUP, 32'h0000_0000);

		// Fill the output side with the receiver held off, then pause until drained.
		hold_req = 1'b1;
		random_run(20);
		drain_results();

		tx_idle_pct = 38;
		rx_idle_pct = 49;
		random_run(130);
		tx_idle_pct = 49;
		rx_idle_pct = 38;
		random_run(130);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_run(50);

		// Run the table to full, hit the full case, then free and reuse some slots.
		repeat (NENT + 10) send_request(REQ_INSERT, $urandom());
		send_request(REQ_INSERT, 32'h0000_0000);
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		random_run(50);

		drain_results();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire
